FILE: hdl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg - shared types and constants of the Taylor sine unit
// Holds the sequencer states, the unit result records and the helpers that
// form the term divisor and the saturating accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

  // Highest series index is limited to MAX_TERMS-1.
  localparam int MAX_TERMS = 32;

  localparam int MAG_W = 63;  // term magnitude, Q31.32, at most 2^63-1
  localparam int X2_W  = 41;  // x^2 as Q.32
  localparam int DEN_W = 12;  // (2i+2)(2i+3) for i up to 30
  localparam int ACC_W = 104; // full product magnitude * x^2

  // Divider: a row of cells, one quotient bit each, per cycle.
  localparam int DIV_CELLS = 8;
  localparam int DIV_BITS  = 64;
  localparam int DIV_STEPS = DIV_BITS / DIV_CELLS;
  localparam int DIV_CW    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MUL,
    ST_DIV
  } tss_state_t;

  typedef struct packed {
    logic             done;
    logic             clip;
    logic [MAG_W-1:0] value;
  } tss_mac_res_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
  } tss_div_res_t;

  typedef struct packed {
    logic signed [63:0] sum;
    logic               clip;
  } tss_acc_t;

  // (2i+2)(2i+3)
  function automatic logic [DEN_W-1:0] term_den(logic [4:0] idx);
    logic [6:0]  a;
    logic [6:0]  b;
    logic [13:0] p;
    a = {1'b0, idx, 1'b0} + 7'd2;
    b = a + 7'd1;
    p = a * b;
    return p[DEN_W-1:0];
  endfunction

  // Add or subtract a magnitude, clip to the int64 limit on overflow.
  function automatic tss_acc_t sat_add(logic signed [63:0] s, logic [MAG_W-1:0] v,
                                       logic neg);
    logic signed [64:0] w;
    tss_acc_t           r;
    if (neg) w = {s[63], s} - {2'b00, v};
    else     w = {s[63], s} + {2'b00, v};
    if (w[64] != w[63]) begin
      r.clip = 1'b1;
      r.sum  = neg ? INT64_MIN : INT64_MAX;
    end else begin
      r.clip = 1'b0;
      r.sum  = w[63:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tss_div_cell.sv
// ----------------------------------------------------------------------------
// tss_div_cell - one restoring division step
// Shifts one dividend bit into the partial remainder and subtracts the
// divisor when it fits.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_div_cell
  import tss_pkg::*;
(
  input  wire logic [DEN_W-1:0] rem_in,
  input  wire logic             bit_in,
  input  wire logic [DEN_W-1:0] den,
  output logic      [DEN_W-1:0] rem_out,
  output logic                  q
);

  logic [DEN_W:0] r2;
  logic [DEN_W:0] diff;

  always_comb begin
    r2   = {rem_in, bit_in};
    diff = r2 - {1'b0, den};
    q    = (r2 >= {1'b0, den});
    rem_out = q ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
  end

endmodule

`default_nettype wire

FILE: hdl/tss_div_row.sv
// ----------------------------------------------------------------------------
// tss_div_row - iterative divider built from a row of division cells
// Each cycle the remainder passes down the row, consuming DIV_CELLS dividend
// bits; the quotient is ready when the done strobe is raised.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_div_row
  import tss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] den,
  output tss_div_res_t          res
);

  logic [DIV_BITS-1:0] dvd;
  logic [DIV_BITS-1:0] quo;
  logic [DEN_W-1:0]    rem;
  logic [DIV_CW-1:0]   cnt;
  logic                run;
  logic                done;

  logic [DEN_W-1:0]     rc [0:DIV_CELLS];
  logic [DIV_CELLS-1:0] qb;

  assign rc[0] = rem;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cells
    tss_div_cell u_cell (
      .rem_in (rc[k]),
      .bit_in (dvd[DIV_BITS-1-k]),
      .den    (den),
      .rem_out(rc[k+1]),
      .q      (qb[DIV_CELLS-1-k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {{(DIV_BITS-MAG_W){1'b0}}, dividend};
      rem <= '0;
    end else if (run) begin
      dvd <= dvd << DIV_CELLS;
      quo <= {quo[DIV_BITS-DIV_CELLS-1:0], qb};
      rem <= rc[DIV_CELLS];
    end
  end

  assign res.done     = done;
  assign res.quotient = quo[MAG_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/tss_mac.sv
// ----------------------------------------------------------------------------
// tss_mac - magnitude times x^2 over four partial products
// One 32x32 product per cycle, registered, then shifted into a wide
// accumulator. Reports the Q31.32 result and whether it clipped.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_mac
  import tss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] mag,
  input  wire logic [X2_W-1:0]  x2q,
  output tss_mac_res_t          res
);

  logic             run;
  logic [1:0]       part;
  logic             pv;
  logic             plast;
  logic [1:0]       psh;
  logic             done;
  logic [63:0]      prod;
  logic [ACC_W-1:0] acc;

  logic [31:0]      opa;
  logic [31:0]      opb;
  logic [ACC_W-1:0] addend;

  always_comb begin
    opa = part[1] ? {1'b0, mag[MAG_W-1:32]} : mag[31:0];
    opb = part[0] ? {{(64-X2_W){1'b0}}, x2q[X2_W-1:32]} : x2q[31:0];
    case (psh)
      2'd0:    addend = {{(ACC_W-64){1'b0}}, prod};
      2'd3:    addend = {{(ACC_W-64){1'b0}}, prod} << 64;
      default: addend = {{(ACC_W-64){1'b0}}, prod} << 32;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
      part <= '0;
    end else begin
      done <= 1'b0;
      pv   <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        part <= '0;
      end else if (run) begin
        pv   <= 1'b1;
        part <= part + 1'b1;
        if (part == 2'd3) run <= 1'b0;
      end
      if (pv && plast) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      prod  <= opa * opb;
      psh   <= part;
      plast <= (part == 2'd3);
    end
    if (start)   acc <= '0;
    else if (pv) acc <= acc + addend;
  end

  assign res.done  = done;
  assign res.clip  = |acc[ACC_W-1:MAG_W+32];
  assign res.value = res.clip ? {MAG_W{1'b1}} : acc[MAG_W+31:32];

endmodule

`default_nettype wire

FILE: hdl/taylor_sine_series_unit.sv
// ----------------------------------------------------------------------------
// taylor_sine_series_unit - partial Taylor series of sine in fixed point
// Sums (-1)^i x^(2i+1)/(2i+1)! for i = 0..n with the term recurrence,
// angle in Q4.27, sum in Q31.32 with saturation.
// ----------------------------------------------------------------------------
// Steps: an accepted item enters the square step, which gives the done strobe
//   for n = 0; else each term passes the partial-product multiplier and then
//   the 8-cell divider row (8 quotient bits a cycle); done follows the last term.
// Throughput: one item at a time; busy stays high until the done strobe.
// Reset: synchronous, active high; clears the sequencer and the strobes.
// The receiver cannot stall: sine_sum and saturated are valid while done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module taylor_sine_series_unit
  import tss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] angle,
  input  wire logic        [4:0]  num_terms,
  output logic                    busy,
  output logic                    done,
  output logic signed [63:0]      sine_sum,
  output logic                    saturated
);

  tss_state_t state;
  tss_state_t state_next;

  // Per-item datapath registers
  logic [31:0]        ax;      // |x|, Q4.27
  logic               neg;     // sign of the current term
  logic [4:0]         lim;     // clamped highest index
  logic [4:0]         idx;     // index of the current term
  logic [X2_W-1:0]    x2q;     // x^2 as Q.32
  logic [MAG_W-1:0]   mag;     // current term magnitude
  logic [DEN_W-1:0]   den;     // divisor for the next term
  logic signed [63:0] sum;
  logic               clip;

  logic               accept;
  logic               mac_start;
  logic               div_start;
  logic               last_term;
  tss_mac_res_t       mac_res;
  tss_div_res_t       div_res;

  logic [63:0]        sq;
  logic [MAG_W-1:0]   mag0;
  tss_acc_t           acc0;
  tss_acc_t           acc_n;
  logic [4:0]         lim_in;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign last_term = (5'(idx + 5'd1) == lim);

  // Clamp the index to the series length.
  always_comb begin
    if (int'(num_terms) > MAX_TERMS - 1) lim_in = 5'(MAX_TERMS - 1);
    else                                 lim_in = num_terms;
  end

  // First term and the accumulate of each new term (sign flips every term).
  always_comb begin
    sq    = ax * ax;
    mag0  = {{(MAG_W-37){1'b0}}, ax, 5'b00000};
    acc0  = sat_add(64'sd0, mag0, neg);
    acc_n = sat_add(sum, div_res.quotient, ~neg);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    mac_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (lim == 5'd0) begin
          state_next = ST_IDLE;
        end else begin
          mac_start  = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mac_res.done) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (last_term) begin
            state_next = ST_IDLE;
          end else begin
            mac_start  = 1'b1;
            state_next = ST_MUL;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result strobe: raise on the cycle the final sum is in place.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == ST_SQUARE) && (lim == 5'd0)) ||
              ((state == ST_DIV) && div_res.done && last_term);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      ax  <= angle[31] ? 32'(-angle) : angle;
      neg <= angle[31];
      lim <= lim_in;
    end
    if (state == ST_SQUARE) begin
      x2q  <= sq[X2_W+21:22];
      mag  <= mag0;
      sum  <= acc0.sum;
      clip <= acc0.clip;
      idx  <= '0;
    end
    if ((state == ST_MUL) && mac_res.done) begin
      clip <= clip | mac_res.clip;
      den  <= term_den(idx);
    end
    if ((state == ST_DIV) && div_res.done) begin
      mag  <= div_res.quotient;
      neg  <= ~neg;
      sum  <= acc_n.sum;
      clip <= clip | acc_n.clip;
      idx  <= 5'(idx + 5'd1);
    end
  end

  // Multiply the magnitude by x^2, then divide by (2i+2)(2i+3).
  tss_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .start(mac_start),
    .mag  (mag),
    .x2q  (x2q),
    .res  (mac_res)
  );

  tss_div_row u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(mac_res.value),
    .den     (den),
    .res     (div_res)
  );

  assign sine_sum  = sum;
  assign saturated = clip;

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a term is in work");

  a_accept_square: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SQUARE))
    else $error("accepted item did not enter the square step");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mac_res.done && div_res.done))
    else $error("multiplier and divider finished together");

  a_mac_in_mul: assert property (@(posedge clk) disable iff (rst)
    mac_res.done |-> (state == ST_MUL))
    else $error("multiplier result outside the multiply step");

endmodule

`default_nettype wire
